### rtl/core/flvp_pkg.sv
// FLV tag parser package: channel item types, queue entry type, result codes
// and the tag format constants. Used by every module of the parser.
// No dependencies.
`timescale 1ns / 1ps

package flvp_pkg;

   // Tag format constants
   localparam logic [7:0] SIG_F        = 8'h46;
   localparam logic [7:0] SIG_L        = 8'h4C;
   localparam logic [7:0] SIG_V        = 8'h56;
   localparam logic [7:0] TYPE_AUDIO   = 8'd8;
   localparam logic [7:0] TYPE_VIDEO   = 8'd9;
   localparam logic [7:0] TYPE_SCRIPT  = 8'd18;
   localparam logic [3:0] HEADER_BYTES = 4'd13;
   localparam logic [31:0] TRAILER_EXTRA = 32'd11;

   // Default depth of the queue between front and back
   localparam int DEF_QUEUE_DEPTH = 4;

   // Result codes
   typedef enum logic [2:0] {
      KIND_BODY      = 3'd0,
      KIND_OK        = 3'd1,
      KIND_BAD_TYPE  = 3'd2,
      KIND_TRAILER   = 3'd3,
      KIND_TRUNC     = 3'd4
   } kind_type;

   // Input item
   typedef struct packed {
      logic [7:0] in_byte;
      logic       buffer_last;
   } req_type;

   // Result item
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tag_kind;
      logic [31:0] tag_time;
      logic [23:0] payload_length;
      logic [7:0]  data_byte;
      logic        body_end;
   } rsp_type;

   // Classified byte as it waits in the queue
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last;
      logic       is_f;
      logic       is_l;
      logic       is_v;
      logic       type_ok;
   } qent_type;

endpackage

### rtl/core/flv_tag_parser.sv
// FLV tag parser top level: front end, queue and back end.
// Depends on flvp_pkg, flvp_front, flvp_queue and flvp_back.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_type: in_byte, buffer_last
//   rsp_     out        rsp_valid/rsp_stall  rsp_type: kind, tag_kind, tag_time,
//                                            payload_length, data_byte, body_end
//
// One byte per cycle sustained while the output is not stalled; a byte that
// gives a result reaches rsp_ through the queue register, then the result
// register. Each byte popped from the queue updates the back end field
// state machine.
// Reset is synchronous and returns the parser to a tag boundary with an
// empty queue. A stalled output holds the result register; input keeps
// flowing into the queue until it fills, then req_stall rises.
`timescale 1ns / 1ps

module flv_tag_parser #(
   parameter int QUEUE_DEPTH = flvp_pkg::DEF_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  flvp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output flvp_pkg::rsp_type rsp_data
);
   import flvp_pkg::*;

   qent_type push_entry;
   qent_type head;
   logic     push;
   logic     pop;
   logic     q_empty;
   logic     q_full;

   flvp_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .entry     (push_entry)
   );

   flvp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   flvp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/flvp_front.sv
// FLV tag parser front end: accepts input bytes and classifies them against
// the signature and tag type codes before they enter the queue.
// Depends on flvp_pkg.
`timescale 1ns / 1ps

module flvp_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  flvp_pkg::req_type  req_data,
   input  logic               q_full,
   output logic               push,
   output flvp_pkg::qent_type entry
);
   import flvp_pkg::*;

   // Stall while the queue has no room
   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   // Classify the byte
   always_comb begin
      entry.in_byte = req_data.in_byte;
      entry.last    = req_data.buffer_last;
      entry.is_f    = (req_data.in_byte == SIG_F);
      entry.is_l    = (req_data.in_byte == SIG_L);
      entry.is_v    = (req_data.in_byte == SIG_V);
      entry.type_ok = (req_data.in_byte == TYPE_AUDIO) ||
                      (req_data.in_byte == TYPE_VIDEO) ||
                      (req_data.in_byte == TYPE_SCRIPT);
   end

endmodule

### rtl/core/flvp_queue.sv
// FLV tag parser queue: short register FIFO of classified bytes between the
// front end and the back end. Depends on flvp_pkg.
`timescale 1ns / 1ps

module flvp_queue #(
   parameter int DEPTH = flvp_pkg::DEF_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  flvp_pkg::qent_type push_entry,
   input  logic               pop,
   output flvp_pkg::qent_type head,
   output logic               empty,
   output logic               full
);
   import flvp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qent_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

endmodule

### rtl/core/flvp_back.sv
// FLV tag parser back end: tag field state machine fed from the queue, with
// the result register toward the output channel. Depends on flvp_pkg.
`timescale 1ns / 1ps

module flvp_back (
   input  logic               clock,
   input  logic               reset,
   input  flvp_pkg::qent_type head,
   input  logic               q_empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output flvp_pkg::rsp_type  rsp_data
);
   import flvp_pkg::*;

   typedef enum logic [7:0] {
      PH_BOUND = 8'b0000_0001,
      PH_SIG   = 8'b0000_0010,
      PH_SKIP  = 8'b0000_0100,
      PH_LEN   = 8'b0000_1000,
      PH_TIME  = 8'b0001_0000,
      PH_SID   = 8'b0010_0000,
      PH_BODY  = 8'b0100_0000,
      PH_TRAIL = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  field_count_ff, field_count_in;
   logic        dropping_ff, dropping_in;
   logic [7:0]  held_type_ff, held_type_in;
   logic [23:0] held_length_ff, held_length_in;
   logic [23:0] body_left_ff, body_left_in;
   logic [31:0] held_time_ff, held_time_in;
   logic [31:0] trailer_acc_ff, trailer_acc_in;

   logic        res_valid;
   kind_type    res_kind;
   logic [7:0]  res_byte;
   logic        res_end;
   rsp_type     res;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   // Take the next byte whenever the result register is free or drains
   assign pop = !q_empty && (!rsp_valid_ff || !rsp_stall);

   // Parse one byte
   always_comb begin
      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      dropping_in    = dropping_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      body_left_in   = body_left_ff;
      held_time_in   = held_time_ff;
      trailer_acc_in = trailer_acc_ff;
      res_valid      = 1'b0;
      res_kind       = KIND_BODY;
      res_byte       = 8'd0;
      res_end        = 1'b0;

      if (!dropping_ff) begin
         case (phase_ff)
            PH_BOUND: begin
               held_type_in   = head.in_byte;
               held_length_in = '0;
               held_time_in   = '0;
               trailer_acc_in = '0;
               body_left_in   = '0;
               field_count_in = '0;
               if (head.is_f) begin
                  phase_in       = PH_SIG;
                  field_count_in = 4'd1;
               end else if (head.type_ok) begin
                  phase_in = PH_LEN;
               end else begin
                  res_valid   = 1'b1;
                  res_kind    = KIND_BAD_TYPE;
                  dropping_in = 1'b1;
                  phase_in    = PH_BOUND;
               end
            end
            PH_SIG: begin
               if ((field_count_ff == 4'd1 && head.is_l) ||
                   (field_count_ff == 4'd2 && head.is_v)) begin
                  field_count_in = field_count_ff + 4'd1;
                  if (field_count_ff == 4'd2) begin
                     phase_in = PH_SKIP;
                  end
               end else begin
                  res_valid      = 1'b1;
                  res_kind       = KIND_BAD_TYPE;
                  dropping_in    = 1'b1;
                  phase_in       = PH_BOUND;
                  field_count_in = '0;
               end
            end
            PH_SKIP: begin
               field_count_in = field_count_ff + 4'd1;
               if (field_count_in >= HEADER_BYTES) begin
                  phase_in       = PH_BOUND;
                  field_count_in = '0;
               end
            end
            PH_LEN: begin
               held_length_in = {held_length_ff[15:0], head.in_byte};
               field_count_in = field_count_ff + 4'd1;
               if (field_count_in >= 4'd3) begin
                  phase_in       = PH_TIME;
                  field_count_in = '0;
               end
            end
            PH_TIME: begin
               if (field_count_ff < 4'd3) begin
                  held_time_in = {8'd0, held_time_ff[15:0], head.in_byte};
               end else begin
                  held_time_in = {head.in_byte, held_time_ff[23:0]};
               end
               field_count_in = field_count_ff + 4'd1;
               if (field_count_in >= 4'd4) begin
                  phase_in       = PH_SID;
                  field_count_in = '0;
               end
            end
            PH_SID: begin
               field_count_in = field_count_ff + 4'd1;
               if (field_count_in >= 4'd3) begin
                  field_count_in = '0;
                  body_left_in   = held_length_ff;
                  phase_in       = (held_length_ff == '0) ? PH_TRAIL : PH_BODY;
               end
            end
            PH_BODY: begin
               res_valid    = 1'b1;
               res_kind     = KIND_BODY;
               res_byte     = head.in_byte;
               body_left_in = body_left_ff - 24'd1;
               if (body_left_in == '0) begin
                  res_end        = 1'b1;
                  phase_in       = PH_TRAIL;
                  field_count_in = '0;
               end
            end
            PH_TRAIL: begin
               trailer_acc_in = {trailer_acc_ff[23:0], head.in_byte};
               field_count_in = field_count_ff + 4'd1;
               if (field_count_in >= 4'd4) begin
                  res_valid      = 1'b1;
                  phase_in       = PH_BOUND;
                  field_count_in = '0;
                  if (trailer_acc_in == ({8'd0, held_length_ff} + TRAILER_EXTRA)) begin
                     res_kind = KIND_OK;
                  end else begin
                     res_kind    = KIND_TRAILER;
                     dropping_in = 1'b1;
                  end
               end
            end
            default: begin
               phase_in       = PH_BOUND;
               field_count_in = '0;
            end
         endcase
      end

      // Report a tag cut off by the end of the buffer
      if (head.last && !(res_valid && res_kind != KIND_BODY) && !dropping_ff &&
          phase_in != PH_BOUND) begin
         res_valid = 1'b1;
         res_kind  = KIND_TRUNC;
         res_byte  = 8'd0;
         res_end   = 1'b0;
      end

      res.kind           = res_kind;
      res.tag_kind       = held_type_in;
      res.tag_time       = held_time_in;
      res.payload_length = held_length_in;
      res.data_byte      = res_byte;
      res.body_end       = res_end;

      // Return to the boundary after the final byte of a buffer
      if (head.last) begin
         phase_in       = PH_BOUND;
         field_count_in = '0;
         dropping_in    = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_BOUND;
         field_count_ff <= '0;
         dropping_ff    <= 1'b0;
      end else if (pop) begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         dropping_ff    <= dropping_in;
      end
   end

   // Held tag fields
   always_ff @(posedge clock) begin
      if (pop) begin
         held_type_ff   <= held_type_in;
         held_length_ff <= held_length_in;
         body_left_ff   <= body_left_in;
         held_time_ff   <= held_time_in;
         trailer_acc_ff <= trailer_acc_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= pop && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_end_on_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.body_end) |-> rsp_data_ff.kind == KIND_BODY)
      else $error("body end flag on a status item");

   a_drop_at_bound: assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> phase_ff == PH_BOUND)
      else $error("dropping outside tag boundary");

   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> (field_count_ff >= 4'd3 && field_count_ff < HEADER_BYTES))
      else $error("header skip count out of range");

endmodule

### test/flv_tag_parser_tb.sv
// Self-checking testbench for flv_tag_parser: drives byte buffers, predicts tag
// results in a scoreboard class and checks every result item field by field.
// Depends on flvp_pkg and flv_tag_parser.
`timescale 1ns / 1ps

module flv_tag_parser_tb;
   import flvp_pkg::*;

   // Parser phases of the predictor
   typedef enum logic [2:0] {
      PH_BOUND = 3'd0,
      PH_SIG   = 3'd1,
      PH_SKIP  = 3'd2,
      PH_LEN   = 3'd3,
      PH_TIME  = 3'd4,
      PH_SID   = 3'd5,
      PH_BODY  = 3'd6,
      PH_TRAIL = 3'd7
   } phase_type;

   localparam int RANDOM_ITEMS = 650;

   // Predicts tag results from accepted bytes and checks result items
   class tag_result_checker;
      rsp_type     pending_results[$];
      int          mismatches;
      phase_type   phase;
      logic [3:0]  cnt;
      logic [7:0]  held_kind;
      logic [23:0] held_len;
      logic [23:0] body_left;
      logic [31:0] held_stamp;
      logic [31:0] trailer_acc;
      bit          dropping;

      function new();
         mismatches = 0;
         clear_state();
      endfunction

      function void clear_state();
         phase = PH_BOUND;
         cnt = '0;
         held_kind = '0;
         held_len = '0;
         body_left = '0;
         held_stamp = '0;
         trailer_acc = '0;
         dropping = 0;
      endfunction

      function void abandon_buffer();
         dropping = 1;
         phase = PH_BOUND;
         cnt = '0;
      endfunction

      task report_mismatch(input string msg);
         $display("%0t: mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      // Advance the parser by one accepted byte; queue the result it causes
      function void consume_byte(input logic [7:0] b, input logic last);
         bit         emit;
         bit         was_dropping;
         kind_type   k;
         logic [7:0] dbyte;
         logic       bend;
         rsp_type    r;
         emit = 0;
         was_dropping = dropping;
         k = KIND_BODY;
         dbyte = '0;
         bend = 0;
         if (!dropping) begin
            case (phase)
               PH_BOUND: begin
                  held_kind = b;
                  held_len = '0;
                  held_stamp = '0;
                  trailer_acc = '0;
                  body_left = '0;
                  cnt = '0;
                  if (b == SIG_F) begin
                     phase = PH_SIG;
                     cnt = 4'd1;
                  end else if (b == TYPE_AUDIO || b == TYPE_VIDEO || b == TYPE_SCRIPT) begin
                     phase = PH_LEN;
                  end else begin
                     k = KIND_BAD_TYPE;
                     emit = 1;
                     abandon_buffer();
                  end
               end
               PH_SIG: begin
                  if ((cnt == 4'd1 && b == SIG_L) || (cnt == 4'd2 && b == SIG_V)) begin
                     cnt++;
                     if (cnt == 4'd3) phase = PH_SKIP;
                  end else begin
                     k = KIND_BAD_TYPE;
                     emit = 1;
                     abandon_buffer();
                  end
               end
               PH_SKIP: begin
                  cnt = cnt + 4'd1;
                  if (cnt >= HEADER_BYTES) begin
                     phase = PH_BOUND;
                     cnt = '0;
                  end
               end
               PH_LEN: begin
                  held_len = {held_len[15:0], b};
                  cnt++;
                  if (cnt >= 4'd3) begin
                     phase = PH_TIME;
                     cnt = '0;
                  end
               end
               PH_TIME: begin
                  // three low bytes big-endian, then the extension byte on top
                  if (cnt < 4'd3) held_stamp = {8'h00, held_stamp[15:0], b};
                  else held_stamp = {b, held_stamp[23:0]};
                  cnt++;
                  if (cnt >= 4'd4) begin
                     phase = PH_SID;
                     cnt = '0;
                  end
               end
               PH_SID: begin
                  cnt++;
                  if (cnt >= 4'd3) begin
                     cnt = '0;
                     body_left = held_len;
                     phase = (held_len == '0) ? PH_TRAIL : PH_BODY;
                  end
               end
               PH_BODY: begin
                  k = KIND_BODY;
                  emit = 1;
                  dbyte = b;
                  body_left = body_left - 24'd1;
                  if (body_left == '0) begin
                     bend = 1;
                     phase = PH_TRAIL;
                     cnt = '0;
                  end
               end
               default: begin
                  trailer_acc = {trailer_acc[23:0], b};
                  cnt++;
                  if (cnt >= 4'd4) begin
                     emit = 1;
                     if (trailer_acc == {8'h00, held_len} + TRAILER_EXTRA) begin
                        k = KIND_OK;
                        phase = PH_BOUND;
                        cnt = '0;
                     end else begin
                        k = KIND_TRAILER;
                        abandon_buffer();
                     end
                  end
               end
            endcase
         end
         // A buffer that ends inside a tag reports truncation instead
         if (last && (!emit || k == KIND_BODY) && !was_dropping && phase != PH_BOUND) begin
            k = KIND_TRUNC;
            emit = 1;
            dbyte = '0;
            bend = 0;
         end
         if (emit) begin
            r.kind = k;
            r.tag_kind = held_kind;
            r.tag_time = held_stamp;
            r.payload_length = held_len;
            r.data_byte = dbyte;
            r.body_end = bend;
            pending_results.push_back(r);
         end
         if (last) clear_state();
      endfunction

      // Compare one result item with the oldest expectation
      task compare_result(input rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d", got.kind));
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
            if (got.tag_kind !== want.tag_kind)
               report_mismatch($sformatf("tag_kind got %0h want %0h",
                                         got.tag_kind, want.tag_kind));
            if (got.tag_time !== want.tag_time)
               report_mismatch($sformatf("tag_time got %0h want %0h",
                                         got.tag_time, want.tag_time));
            if (got.payload_length !== want.payload_length)
               report_mismatch($sformatf("payload_length got %0h want %0h",
                                         got.payload_length, want.payload_length));
            if (got.data_byte !== want.data_byte)
               report_mismatch($sformatf("data_byte got %0h want %0h",
                                         got.data_byte, want.data_byte));
            if (got.body_end !== want.body_end)
               report_mismatch($sformatf("body_end got %0d want %0d",
                                         got.body_end, want.body_end));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   tag_result_checker tag_check;
   logic [7:0]        buffer_bytes[$];
   int                bytes_sent;
   bit                req_calm;
   bit                rsp_calm;

   flv_tag_parser DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Wait cycles per item; now and then switch into or out of a run without gaps
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Offer one byte after a random gap and hold it until accepted
   task send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{in_byte: b, buffer_last: last};
      do @(posedge clock); while (req_stall);
      tag_check.consume_byte(b, last);
      bytes_sent++;
   endtask

   // Send the assembled buffer, flagging its final byte
   task send_buffer();
      int i;
      for (i = 0; i < buffer_bytes.size(); i++)
         send_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
      buffer_bytes.delete();
   endtask

   function automatic void push_be(input logic [31:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) buffer_bytes.push_back(v[8*i +: 8]);
   endfunction

   // Append one tag; returns 1 when the body is cut short and the buffer must end
   function automatic bit push_tag(input logic [7:0] kind_byte);
      logic [23:0] len;
      logic [31:0] trailer;
      int          body_bytes;
      bit          cut;
      cut = 0;
      if ($urandom_range(0, 15) == 0) begin
         len = 24'($urandom_range(25, 24'hFFFFFF));
         body_bytes = $urandom_range(0, 6);
         cut = 1;
      end else begin
         len = 24'($urandom_range(0, 8));
         body_bytes = int'(len);
      end
      buffer_bytes.push_back(kind_byte);
      push_be({8'h00, len}, 3);
      push_be($urandom, 4);
      push_be($urandom, 3);
      repeat (body_bytes) buffer_bytes.push_back(8'($urandom));
      if (!cut) begin
         trailer = {8'h00, len} + TRAILER_EXTRA;
         if ($urandom_range(0, 7) == 0) trailer = trailer ^ (32'd1 << $urandom_range(0, 31));
         push_be(trailer, 4);
      end
      return cut;
   endfunction

   // Build a mostly well-formed random buffer, sometimes noise or cut short
   task build_random_buffer();
      int          mode;
      int          ntags;
      int          sel;
      logic [7:0]  kind_byte;
      bit          cut;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom));
      end else begin
         cut = 0;
         if ($urandom_range(0, 3) == 0) begin
            buffer_bytes.push_back(SIG_F);
            buffer_bytes.push_back(SIG_L);
            buffer_bytes.push_back(SIG_V);
            repeat (10) buffer_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 4) == 0) cut = 1;
         end
         ntags = $urandom_range(1, 3);
         while (!cut && ntags > 0) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) kind_byte = TYPE_AUDIO;
            else if (sel < 6) kind_byte = TYPE_VIDEO;
            else if (sel < 8) kind_byte = TYPE_SCRIPT;
            else if (sel == 8) kind_byte = SIG_F;
            else kind_byte = 8'($urandom);
            if (kind_byte == SIG_F) begin
               // broken or partial signature
               buffer_bytes.push_back(SIG_F);
               buffer_bytes.push_back($urandom_range(0, 1) ? SIG_L : 8'($urandom));
               cut = 1;
            end else begin
               cut = push_tag(kind_byte);
            end
            ntags--;
         end
         if ($urandom_range(0, 5) == 0)
            buffer_bytes = buffer_bytes[0 : $urandom_range(0, buffer_bytes.size() - 1)];
      end
      send_buffer();
   endtask

   // Result side: random stall per item, check every accepted result
   initial begin
      int n;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         n = draw_gap(rsp_calm);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         tag_check.compare_result(rsp_data);
      end
   end

   // Stimulus and end of run
   initial begin
      tag_check = new();
      bytes_sent = 0;
      req_calm = 0;
      rsp_calm = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bad type bytes at both extremes, each ending its buffer
      buffer_bytes.push_back(8'h00);
      send_buffer();
      buffer_bytes.push_back(8'hFF);
      send_buffer();
      // broken signature
      buffer_bytes.push_back(SIG_F);
      buffer_bytes.push_back(8'h58);
      send_buffer();
      // buffer ends inside the signature
      buffer_bytes.push_back(SIG_F);
      buffer_bytes.push_back(SIG_L);
      send_buffer();
      // lone type byte
      buffer_bytes.push_back(TYPE_VIDEO);
      send_buffer();
      // buffer ends while dropping
      buffer_bytes.push_back(8'h07);
      buffer_bytes.push_back(8'h55);
      send_buffer();
      // zero-length body with a full timestamp
      buffer_bytes.push_back(TYPE_SCRIPT);
      push_be(32'h0, 3);
      push_be(32'hFFFF_FFFF, 4);
      push_be(32'h0, 3);
      push_be({8'h00, 24'h0} + TRAILER_EXTRA, 4);
      send_buffer();

      bytes_sent = 0;
      while (bytes_sent < RANDOM_ITEMS) build_random_buffer();
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (tag_check.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tag_check.pending_results.size() != 0)
         tag_check.report_mismatch("expected results left over");
      if (tag_check.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Hard stop
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
